// ===== rtl/icd_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the IR cliff detector.
// No dependencies.
package icd_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned DELTA_W    = 15;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned LIM_W      = 15;
  localparam int unsigned HIST_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned AMP_SHIFT  = 4;

  localparam logic [DELTA_W-1:0] DELTA_MAX       = 15'h7FFF;
  localparam logic [LIM_W-1:0]   LOW_LIGHT_RESET = 15'd1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIGHT     = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_lit;
    logic [SAMPLE_W-1:0] sample_dark;
  } icd_in_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic               cliff_now;
    logic [HIST_W-1:0]  history;
    logic               detected;
  } icd_out_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold_on;
    logic [THR_W-1:0] threshold_off;
    logic [LIM_W-1:0] low_light_limit;
  } icd_cfg_t;

endpackage

// ===== rtl/icd_decide.sv =====
`timescale 1ns / 1ps
// Per-block decision logic: difference, peak hold, low-light gain, hysteresis.
// Depends on icd_pkg.
module icd_decide #(
  parameter int unsigned SUM_W = 14
) (
  input  icd_pkg::icd_cfg_t cfg_i,
  input  logic [SUM_W-1:0]  lit_sum_i,
  input  logic [SUM_W-1:0]  dark_sum_i,
  input  logic [SUM_W-1:0]  prev_raw_i,
  input  logic              last_cliff_i,
  output logic [SUM_W-1:0]  raw_o,
  output logic [icd_pkg::DELTA_W-1:0] delta_o,
  output logic              cliff_o
);
  import icd_pkg::*;

  localparam int unsigned EXT_W = (SUM_W > DELTA_W) ? SUM_W : DELTA_W;
  localparam int unsigned TOT_W = ((SUM_W + 1) > LIM_W) ? (SUM_W + 1) : LIM_W;

  logic [SUM_W-1:0]   peak;
  logic [DELTA_W-1:0] delta_sat;
  logic [TOT_W-1:0]   total;
  logic               low_light;
  logic [THR_W-1:0]   delta_ext;

  always_comb begin
    raw_o = (dark_sum_i > lit_sum_i) ? (dark_sum_i - lit_sum_i) : (lit_sum_i - dark_sum_i);
    peak  = (raw_o > prev_raw_i) ? raw_o : prev_raw_i;

    if (EXT_W'(peak) > EXT_W'(DELTA_MAX)) begin
      delta_sat = DELTA_MAX;
    end else begin
      delta_sat = DELTA_W'(peak);
    end

    total     = TOT_W'(lit_sum_i) + TOT_W'(dark_sum_i);
    low_light = (total < TOT_W'(cfg_i.low_light_limit)) &&
                (THR_W'(delta_sat) < cfg_i.threshold_off);

    // Small signal in dim light: boost by 16, clamp at full scale
    if (low_light) begin
      if (delta_sat > (DELTA_MAX >> AMP_SHIFT)) begin
        delta_o = DELTA_MAX;
      end else begin
        delta_o = DELTA_W'(delta_sat << AMP_SHIFT);
      end
    end else begin
      delta_o = delta_sat;
    end

    delta_ext = THR_W'(delta_o);
    if (delta_ext >= cfg_i.threshold_on) begin
      cliff_o = 1'b0;
    end else if (delta_ext < cfg_i.threshold_off) begin
      cliff_o = 1'b1;
    end else begin
      cliff_o = last_cliff_i;
    end
  end

endmodule

// ===== rtl/ir_cliff_detector_core.sv =====
`timescale 1ns / 1ps
// IR cliff detector top level: frame accumulation, block register, result register.
// Depends on icd_pkg and icd_decide.
//
// Usage: one instance per IR sensor channel.
// - Input channel (in_valid_i / in_ready_o / in_data_i): one item per frame, a
//   lit and a dark ADC sample. Items are summed over BLOCK_FRAMES frames.
// - Output channel (out_valid_o / out_ready_i / out_data_o): one item per block,
//   produced by the last frame of the block; other frames produce nothing.
// - Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): single-cycle writes of
//   threshold_on, threshold_off and low_light_limit; unknown indexes ignored.
//   Write only while the block is idle.
// Path: once a block's last frame is accepted, its result passes through the block
//   register, then the result register, before it appears on out_valid_o.
// Throughput: one input item per cycle while in_ready_o is high; the adders, the
//   difference and the threshold compares each sit between two registers.
// Stall: while the result register is held, the block register still takes the
//   next block's sums, so input only stops when both are full.
// Reset: clears sums, frame count, peak hold, decision history, valid flags and
//   sets config to threshold_on = 0, threshold_off = 0, low_light_limit = 1024.
module ir_cliff_detector_core #(
  parameter int unsigned BLOCK_FRAMES = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [icd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [icd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  icd_pkg::icd_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output icd_pkg::icd_out_t              out_data_o
);
  import icd_pkg::*;

  localparam int unsigned FC_W  = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
  localparam int unsigned SUM_W = SAMPLE_W + FC_W;
  localparam logic [FC_W-1:0] FC_LAST = FC_W'(BLOCK_FRAMES - 1);

  // Config registers
  icd_cfg_t cfg_q, cfg_d;

  // Frame accumulation
  logic [FC_W-1:0]  fc_q, fc_d;
  logic [SUM_W-1:0] lit_acc_q, lit_acc_d;
  logic [SUM_W-1:0] dark_acc_q, dark_acc_d;
  logic [SUM_W-1:0] lit_next, dark_next;

  // Block register (final sums of one block)
  logic             blk_valid_q, blk_valid_d;
  logic [SUM_W-1:0] blk_lit_q, blk_dark_q;

  // Decision state and result register
  logic [SUM_W-1:0]  prev_raw_q;
  logic [HIST_W-1:0] hist_q, hist_d;
  logic              out_valid_q, out_valid_d;
  icd_out_t          out_q;

  logic               in_accept, last_frame, out_free, blk_adv;
  logic [SUM_W-1:0]   raw;
  logic [DELTA_W-1:0] delta;
  logic               cliff;

  assign out_free   = !out_valid_q || out_ready_i;
  assign blk_adv    = blk_valid_q && out_free;
  assign in_ready_o = !blk_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign last_frame = (fc_q == FC_LAST);

  assign lit_next  = lit_acc_q + SUM_W'(in_data_i.sample_lit);
  assign dark_next = dark_acc_q + SUM_W'(in_data_i.sample_dark);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD_ON:  cfg_d.threshold_on    = cfg_wdata_i;
        CFG_THRESHOLD_OFF: cfg_d.threshold_off   = cfg_wdata_i;
        CFG_LOW_LIGHT:     cfg_d.low_light_limit = cfg_wdata_i[LIM_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    fc_d        = fc_q;
    lit_acc_d   = lit_acc_q;
    dark_acc_d  = dark_acc_q;
    blk_valid_d = blk_adv ? 1'b0 : blk_valid_q;
    if (in_accept) begin
      if (last_frame) begin
        fc_d        = '0;
        lit_acc_d   = '0;
        dark_acc_d  = '0;
        blk_valid_d = 1'b1;
      end else begin
        fc_d       = fc_q + FC_W'(1);
        lit_acc_d  = lit_next;
        dark_acc_d = dark_next;
      end
    end
  end

  icd_decide #(
    .SUM_W(SUM_W)
  ) u_decide (
    .cfg_i       (cfg_q),
    .lit_sum_i   (blk_lit_q),
    .dark_sum_i  (blk_dark_q),
    .prev_raw_i  (prev_raw_q),
    .last_cliff_i(hist_q[0]),
    .raw_o       (raw),
    .delta_o     (delta),
    .cliff_o     (cliff)
  );

  assign hist_d = {hist_q[HIST_W-2:0], cliff};

  always_comb begin
    out_valid_d = out_valid_q;
    if (blk_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_on    <= '0;
      cfg_q.threshold_off   <= '0;
      cfg_q.low_light_limit <= LOW_LIGHT_RESET;
      fc_q                  <= '0;
      lit_acc_q             <= '0;
      dark_acc_q            <= '0;
      blk_valid_q           <= 1'b0;
      prev_raw_q            <= '0;
      hist_q                <= '0;
      out_valid_q           <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      fc_q        <= fc_d;
      lit_acc_q   <= lit_acc_d;
      dark_acc_q  <= dark_acc_d;
      blk_valid_q <= blk_valid_d;
      out_valid_q <= out_valid_d;
      if (blk_adv) begin
        prev_raw_q <= raw;
        hist_q     <= hist_d;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept && last_frame) begin
      blk_lit_q  <= lit_next;
      blk_dark_q <= dark_next;
    end
    if (blk_adv) begin
      out_q.delta     <= delta;
      out_q.cliff_now <= cliff;
      out_q.history   <= hist_d;
      out_q.detected  <= |hist_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_fc_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_frame) |=> (fc_q == '0 && blk_valid_q))
    else $error("frame count did not wrap at block end");

  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_adv |=> (hist_q[HIST_W-1:1] == $past(hist_q[HIST_W-2:0])))
    else $error("decision history did not shift by one");

  a_out_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(blk_adv) |-> (out_q.history == hist_q && out_q.detected == (hist_q != '0)))
    else $error("result history out of step with decision state");

  a_blk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_valid_q && !out_free) |=> (blk_valid_q && $stable(blk_lit_q) && $stable(blk_dark_q)))
    else $error("block register lost sums under stall");

endmodule
